>>> src/bas_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and the microcode program of the bitonic array search.
// Used by bas_datapath and bitonic_array_search; depends on nothing else.
package bas_pkg;

  localparam int MaxElems = 1024;
  localparam int AddrW    = $clog2(MaxElems);
  localparam int CntW     = AddrW + 1;
  localparam int IdxW     = AddrW + 2;
  localparam int DataW    = 32;
  localparam int PosW     = 10;
  localparam int StepW    = 4;

  // request codes carried on tuser
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // program steps
  localparam logic [StepW-1:0] S_INIT      = 4'd0;
  localparam logic [StepW-1:0] S_PK_MID    = 4'd1;
  localparam logic [StepW-1:0] S_PK_RDL    = 4'd2;
  localparam logic [StepW-1:0] S_PK_RDM    = 4'd3;
  localparam logic [StepW-1:0] S_PK_RDR    = 4'd4;
  localparam logic [StepW-1:0] S_PK_EVAL   = 4'd5;
  localparam logic [StepW-1:0] S_PK_CHK    = 4'd6;
  localparam logic [StepW-1:0] S_RS_MID    = 4'd7;
  localparam logic [StepW-1:0] S_RS_RD     = 4'd8;
  localparam logic [StepW-1:0] S_RS_EVAL   = 4'd9;
  localparam logic [StepW-1:0] S_FL_INIT   = 4'd10;
  localparam logic [StepW-1:0] S_FL_MID    = 4'd11;
  localparam logic [StepW-1:0] S_FL_RD     = 4'd12;
  localparam logic [StepW-1:0] S_FL_EVAL   = 4'd13;
  localparam logic [StepW-1:0] S_DONE_MISS = 4'd14;
  localparam logic [StepW-1:0] S_DONE_HIT  = 4'd15;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_MID,
    OP_LATCH_L,
    OP_LATCH_M,
    OP_PEAK,
    OP_PEAK_CHK,
    OP_PART,
    OP_FALL_INIT,
    OP_DONE_MISS,
    OP_DONE_HIT
  } op_e;

  typedef enum logic [1:0] {
    ADDR_MID,
    ADDR_MID_M1,
    ADDR_MID_P1
  } addr_sel_e;

  typedef struct packed {
    op_e              op;
    addr_sel_e        addr_sel;
    logic             rising;
    logic [StepW-1:0] jmp;
    logic [StepW-1:0] nxt;
  } ucw_t;

  typedef struct packed {
    logic      run;
    op_e       op;
    addr_sel_e addr_sel;
    logic      rising;
    logic      start;
    logic      append;
    logic      clear;
  } dp_ctrl_t;

  typedef struct packed {
    logic                   cond;
    logic signed [IdxW-1:0] res;
    logic                   ovf;
  } dp_stat_t;

  function automatic ucw_t mk(input op_e op, input addr_sel_e sel, input logic rising,
                              input logic [StepW-1:0] jmp, input logic [StepW-1:0] nxt);
    ucw_t w;
    w.op       = op;
    w.addr_sel = sel;
    w.rising   = rising;
    w.jmp      = jmp;
    w.nxt      = nxt;
    return w;
  endfunction

  function automatic ucw_t ucode_rom(input logic [StepW-1:0] step);
    ucw_t w;
    w = mk(OP_NOP, ADDR_MID, 1'b0, S_DONE_MISS, S_DONE_MISS);
    unique case (step)
      S_INIT:      w = mk(OP_INIT,      ADDR_MID,    1'b0, S_DONE_MISS, S_PK_MID);
      S_PK_MID:    w = mk(OP_MID,       ADDR_MID,    1'b0, S_DONE_MISS, S_PK_RDL);
      S_PK_RDL:    w = mk(OP_NOP,       ADDR_MID_M1, 1'b0, S_PK_RDM,    S_PK_RDM);
      S_PK_RDM:    w = mk(OP_LATCH_L,   ADDR_MID,    1'b0, S_PK_RDR,    S_PK_RDR);
      S_PK_RDR:    w = mk(OP_LATCH_M,   ADDR_MID_P1, 1'b0, S_PK_EVAL,   S_PK_EVAL);
      S_PK_EVAL:   w = mk(OP_PEAK,      ADDR_MID,    1'b0, S_PK_CHK,    S_PK_MID);
      S_PK_CHK:    w = mk(OP_PEAK_CHK,  ADDR_MID,    1'b0, S_DONE_HIT,  S_RS_MID);
      S_RS_MID:    w = mk(OP_MID,       ADDR_MID,    1'b1, S_FL_INIT,   S_RS_RD);
      S_RS_RD:     w = mk(OP_NOP,       ADDR_MID,    1'b1, S_RS_EVAL,   S_RS_EVAL);
      S_RS_EVAL:   w = mk(OP_PART,      ADDR_MID,    1'b1, S_DONE_HIT,  S_RS_MID);
      S_FL_INIT:   w = mk(OP_FALL_INIT, ADDR_MID,    1'b0, S_FL_MID,    S_FL_MID);
      S_FL_MID:    w = mk(OP_MID,       ADDR_MID,    1'b0, S_DONE_MISS, S_FL_RD);
      S_FL_RD:     w = mk(OP_NOP,       ADDR_MID,    1'b0, S_FL_EVAL,   S_FL_EVAL);
      S_FL_EVAL:   w = mk(OP_PART,      ADDR_MID,    1'b0, S_DONE_HIT,  S_FL_MID);
      S_DONE_MISS: w = mk(OP_DONE_MISS, ADDR_MID,    1'b0, S_INIT,      S_INIT);
      S_DONE_HIT:  w = mk(OP_DONE_HIT,  ADDR_MID,    1'b0, S_INIT,      S_INIT);
    endcase
    return w;
  endfunction

endpackage

>>> src/bas_datapath.sv
`timescale 1ns / 1ps
// Element store, search bounds, probe registers and branch conditions.
// Driven one micro-op per cycle by the sequencer in bitonic_array_search; uses bas_pkg.
module bas_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bas_pkg::dp_ctrl_t               ctrl_i,
  input  logic signed [bas_pkg::DataW-1:0] elem_i,
  input  logic signed [bas_pkg::DataW-1:0] key_i,
  output bas_pkg::dp_stat_t               stat_o
);

  logic signed [bas_pkg::DataW-1:0] mem [bas_pkg::MaxElems];
  logic signed [bas_pkg::DataW-1:0] rd_q;
  logic signed [bas_pkg::DataW-1:0] va_q, vb_q, key_q;
  logic signed [bas_pkg::IdxW-1:0]  lo_q, hi_q, mid_q, peak_q, res_q;
  logic signed [bas_pkg::IdxW-1:0]  lo_d, hi_d, mid_d, peak_d, res_d;
  logic signed [bas_pkg::IdxW-1:0]  n_s, nm1, mid_m1, mid_p1, mid_pl, mid_mi, pk_m1, pk_p1;
  logic signed [bas_pkg::IdxW:0]    sum;
  logic [bas_pkg::CntW-1:0]         cnt_q, cnt_d;
  logic                             ovf_q, ovf_d;
  logic                             full, wr_en, left_ok, right_ok, cond;
  logic [bas_pkg::AddrW-1:0]        raddr;

  assign full   = (cnt_q == bas_pkg::CntW'(bas_pkg::MaxElems));
  assign wr_en  = ctrl_i.append && !full;
  assign n_s    = signed'(bas_pkg::IdxW'(cnt_q));
  assign nm1    = n_s - bas_pkg::IdxW'(1);
  assign mid_m1 = mid_q - bas_pkg::IdxW'(1);
  assign mid_p1 = mid_q + bas_pkg::IdxW'(1);
  assign mid_pl = mid_q + bas_pkg::IdxW'(1);
  assign mid_mi = mid_q - bas_pkg::IdxW'(1);
  assign pk_m1  = peak_q - bas_pkg::IdxW'(1);
  assign pk_p1  = peak_q + bas_pkg::IdxW'(1);
  assign sum    = (bas_pkg::IdxW+1)'(lo_q) + (bas_pkg::IdxW+1)'(hi_q);

  always_comb begin
    unique case (ctrl_i.addr_sel)
      bas_pkg::ADDR_MID_M1: raddr = mid_m1[bas_pkg::AddrW-1:0];
      bas_pkg::ADDR_MID_P1: raddr = mid_p1[bas_pkg::AddrW-1:0];
      default:              raddr = mid_q[bas_pkg::AddrW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[bas_pkg::AddrW-1:0]] <= elem_i;
    end
    rd_q <= mem[raddr];
  end

  // rd_q holds the element right of mid during the peak evaluation
  assign left_ok  = (mid_q == '0) || (va_q < vb_q);
  assign right_ok = (mid_q == hi_q) || (rd_q < vb_q);

  always_comb begin
    lo_d   = lo_q;
    hi_d   = hi_q;
    mid_d  = mid_q;
    peak_d = peak_q;
    res_d  = res_q;
    cond   = 1'b0;
    unique case (ctrl_i.op)
      bas_pkg::OP_INIT: begin
        lo_d = '0;
        hi_d = nm1;
        cond = (cnt_q == '0);
      end
      bas_pkg::OP_MID: begin
        mid_d = sum[bas_pkg::IdxW:1];
        cond  = (lo_q > hi_q);
      end
      bas_pkg::OP_PEAK: begin
        cond   = left_ok && right_ok;
        peak_d = mid_q;
        if ((mid_q < hi_q) && (vb_q < rd_q)) begin
          lo_d = mid_pl;
        end else begin
          hi_d = mid_mi;
        end
      end
      bas_pkg::OP_PEAK_CHK: begin
        cond  = (vb_q == key_q);
        res_d = peak_q;
        lo_d  = '0;
        hi_d  = pk_m1;
      end
      bas_pkg::OP_PART: begin
        cond  = (rd_q == key_q);
        res_d = mid_q;
        if ((rd_q < key_q) == ctrl_i.rising) begin
          lo_d = mid_pl;
        end else begin
          hi_d = mid_mi;
        end
      end
      bas_pkg::OP_FALL_INIT: begin
        lo_d = pk_p1;
        hi_d = nm1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      key_q <= key_i;
    end
    if (ctrl_i.run) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      mid_q  <= mid_d;
      peak_q <= peak_d;
      res_q  <= res_d;
      if (ctrl_i.op == bas_pkg::OP_LATCH_L) begin
        va_q <= rd_q;
      end
      if (ctrl_i.op == bas_pkg::OP_LATCH_M) begin
        vb_q <= rd_q;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (ctrl_i.clear) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end else if (ctrl_i.append) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  assign stat_o.cond = cond;
  assign stat_o.res  = res_q;
  assign stat_o.ovf  = ovf_q;

endmodule

>>> src/bitonic_array_search.sv
`timescale 1ns / 1ps
// Top level of the bitonic array search: stream ports, microcode sequencer, result register.
// Depends on bas_pkg and bas_datapath.
//
// Usage: each input beat carries a request in s_axis_tuser_i (append, search, clear) with
// the element and the key in s_axis_tdata_i. Append and clear finish in the cycle the beat
// is taken and give no output beat. An append to a full store (1024 elements) is dropped and
// sets the overflow flag until the next clear.
// A search runs a microcode program from a 16-word read-only table: peak search, then the
// rising part, then the falling part. Each peak probe makes three reads of the store, which
// has a single read port; each probe of either part makes one read, and setup, part ends
// and finish take further steps. The store read port is the limit. One search runs at a
// time; s_axis_tready_o is low while it runs. The result beat sits in an output register,
// so the next request is taken while it waits. If the receiver stalls and the register is
// still full, the program holds at its last step until the old beat is taken.
// Reset clears the element count, the overflow flag and all control state; stored elements
// are not cleared.
module bitonic_array_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // elem_value[31:0], key[63:32]
  input  logic [1:0]  s_axis_tuser_i,  // req_type[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // found[0], position[10:1], overflow[11], zero[15:12]
);

  bas_pkg::ucw_t               ucw;
  bas_pkg::dp_ctrl_t           ctrl;
  bas_pkg::dp_stat_t           stat;
  logic                        busy_q, busy_d;
  logic [bas_pkg::StepW-1:0]   step_q, step_d;
  logic                        in_acc, out_acc, slot_free, is_done, finish;
  logic                        mv_q, mv_d;
  logic                        found_q, ovf_out_q;
  logic [bas_pkg::PosW-1:0]    pos_q;

  assign ucw       = bas_pkg::ucode_rom(step_q);
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc   = mv_q && m_axis_tready_i;
  assign slot_free = !mv_q || m_axis_tready_i;
  assign is_done   = (ucw.op == bas_pkg::OP_DONE_MISS) || (ucw.op == bas_pkg::OP_DONE_HIT);
  assign finish    = busy_q && is_done && slot_free;

  assign s_axis_tready_o = !busy_q;

  assign ctrl.run      = busy_q && !is_done;
  assign ctrl.op       = ucw.op;
  assign ctrl.addr_sel = ucw.addr_sel;
  assign ctrl.rising   = ucw.rising;
  assign ctrl.start    = in_acc && (s_axis_tuser_i == bas_pkg::REQ_SEARCH);
  assign ctrl.append   = in_acc && (s_axis_tuser_i == bas_pkg::REQ_APPEND);
  assign ctrl.clear    = in_acc && (s_axis_tuser_i == bas_pkg::REQ_CLEAR);

  bas_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .elem_i (signed'(s_axis_tdata_i[31:0])),
    .key_i  (signed'(s_axis_tdata_i[63:32])),
    .stat_o (stat)
  );

  // advance the program; jump where the step's condition holds
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (ctrl.start) begin
      busy_d = 1'b1;
      step_d = bas_pkg::S_INIT;
    end else if (finish) begin
      busy_d = 1'b0;
    end else if (ctrl.run) begin
      step_d = stat.cond ? ucw.jmp : ucw.nxt;
    end
  end

  always_comb begin
    mv_d = mv_q;
    if (finish) begin
      mv_d = 1'b1;
    end else if (out_acc) begin
      mv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= bas_pkg::S_INIT;
      mv_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      mv_q   <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      found_q   <= (ucw.op == bas_pkg::OP_DONE_HIT);
      pos_q     <= (ucw.op == bas_pkg::OP_DONE_HIT) ? bas_pkg::PosW'(stat.res) : '0;
      ovf_out_q <= stat.ovf;
    end
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = {4'b0000, ovf_out_q, pos_q, found_q};

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for bitonic_array_search: loads bitonic, flat and ragged arrays, searches,
// clears and stray requests, scoring every result beat against a behavioral search model.
// Depends on bas_pkg and the bitonic_array_search RTL.
module testbench;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam longint SMin = -64'sd2147483648;
  localparam longint SMax = 64'sd2147483647;

  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] elem;
    logic [31:0] key;
  } request_t;

  typedef struct packed {
    logic                     found;
    logic [bas_pkg::PosW-1:0] position;
    logic                     overflow;
  } search_result_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [63:0] s_data  = '0;
  logic [1:0]  s_user  = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;

  request_t       request_queue[$];
  request_t       beat_on_bus;
  search_result_t expected_results[$];
  int unsigned    beats_in      = 0;
  int unsigned    err_cnt       = 0;
  int unsigned    counted_items = 0;
  logic           calm;

  logic signed [31:0] model_mem [bas_pkg::MaxElems];
  int                 model_cnt = 0;
  logic               model_ovf = 1'b0;

  logic [31:0] gen_arr[$];

  always #4 clk_i = ~clk_i;

  bitonic_array_search u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  assign calm = (beats_in >= 300) && (beats_in < 600);

  function automatic int find_peak_index(int n);
    int   lo, hi, mid;
    logic left_ok, right_ok;
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid      = (lo + hi) / 2;
      left_ok  = (mid == 0) || (model_mem[mid-1] < model_mem[mid]);
      right_ok = (mid == hi) || (model_mem[mid+1] < model_mem[mid]);
      if (left_ok && right_ok) return mid;
      if (mid < hi && model_mem[mid] < model_mem[mid+1]) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic int search_side(int lo, int hi, logic signed [31:0] key, logic rising);
    int mid;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (model_mem[mid] == key) return mid;
      if ((model_mem[mid] < key) == rising) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic int locate_key(logic signed [31:0] key);
    int peak, idx;
    if (model_cnt <= 0) return -1;
    peak = find_peak_index(model_cnt);
    if (peak < 0) return -1;
    if (model_mem[peak] == key) return peak;
    idx = search_side(0, peak - 1, key, 1'b1);
    if (idx >= 0) return idx;
    return search_side(peak + 1, model_cnt - 1, key, 1'b0);
  endfunction

  function automatic void bitonic_model_step(request_t r);
    int             idx;
    search_result_t res;
    case (r.req)
      bas_pkg::REQ_APPEND: begin
        if (model_cnt < bas_pkg::MaxElems) begin
          model_mem[model_cnt] = r.elem;
          model_cnt++;
        end else begin
          model_ovf = 1'b1;
        end
      end
      bas_pkg::REQ_CLEAR: begin
        model_cnt = 0;
        model_ovf = 1'b0;
      end
      bas_pkg::REQ_SEARCH: begin
        idx          = locate_key(r.key);
        res.found    = (idx >= 0);
        res.position = (idx >= 0) ? idx[bas_pkg::PosW-1:0] : '0;
        res.overflow = model_ovf;
        expected_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_request(logic [1:0] req, logic [31:0] elem, logic [31:0] key);
    request_t r;
    r.req  = req;
    r.elem = elem;
    r.key  = key;
    request_queue.push_back(r);
    if (req != REQ_UNUSED) counted_items++;
    if (req == bas_pkg::REQ_APPEND && gen_arr.size() < bas_pkg::MaxElems) gen_arr.push_back(elem);
    if (req == bas_pkg::REQ_CLEAR) gen_arr.delete();
  endfunction

  function automatic void queue_append(logic [31:0] v);
    queue_request(bas_pkg::REQ_APPEND, v, $urandom);
  endfunction

  function automatic void queue_search(logic [31:0] k);
    queue_request(bas_pkg::REQ_SEARCH, $urandom, k);
  endfunction

  function automatic void queue_clear();
    queue_request(bas_pkg::REQ_CLEAR, $urandom, $urandom);
  endfunction

  // mostly keys that are stored, some neighbors of stored values, some anything
  function automatic logic [31:0] pick_key();
    int          sel;
    logic [31:0] pick;
    sel = $urandom_range(0, 9);
    if (gen_arr.size() == 0 || sel >= 8) return $urandom;
    pick = gen_arr[$urandom_range(0, gen_arr.size() - 1)];
    if (sel < 6) return pick;
    return (sel == 6) ? pick + 1 : pick - 1;
  endfunction

  function automatic void load_bitonic(int n, int top, bit fine);
    longint vals [bas_pkg::MaxElems];
    longint lowest, floor_v, span, peak_v;
    int     i, sel;
    vals[top] = 0;
    for (i = top - 1; i >= 0; i--)
      vals[i] = vals[i+1] - (fine ? $urandom_range(1, 3) : $urandom_range(1, 1 << 21));
    for (i = top + 1; i < n; i++)
      vals[i] = vals[i-1] - (fine ? $urandom_range(1, 3) : $urandom_range(1, 1 << 21));
    lowest  = (vals[0] < vals[n-1]) ? vals[0] : vals[n-1];
    floor_v = SMin - lowest;
    span    = SMax - floor_v + 1;
    sel     = $urandom_range(0, 9);
    if (sel == 0) peak_v = SMax;
    else if (sel == 1) peak_v = floor_v;
    else peak_v = floor_v + (longint'({$urandom, $urandom} >> 1) % span);
    for (i = 0; i < n; i++) queue_append(32'(vals[i] + peak_v));
  endfunction

  // drive request beats; step the model with each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic gap;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        bitonic_model_step(beat_on_bus);
        beats_in <= beats_in + 1;
      end
      if (!s_valid || s_ready) begin
        gap = !calm && ($urandom_range(0, 99) < 18);
        if (request_queue.size() != 0 && !gap) begin
          beat_on_bus = request_queue.pop_front();
          s_valid <= 1'b1;
          s_data  <= {beat_on_bus.key, beat_on_bus.elem};
          s_user  <= beat_on_bus.req;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    search_result_t got, want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        got.found    = m_data[0];
        got.position = m_data[10:1];
        got.overflow = m_data[11];
        if (expected_results.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat: found %0b position %0d overflow %0b",
                   $time, got.found, got.position, got.overflow);
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found || got.position !== want.position ||
              got.overflow !== want.overflow) begin
            err_cnt++;
            $display("%0t: mismatch: expected found %0b position %0d overflow %0b, %s",
                     $time, want.found, want.position, want.overflow,
                     $sformatf("got found %0b position %0d overflow %0b",
                               got.found, got.position, got.overflow));
          end
        end
      end
      m_ready <= calm || ($urandom_range(0, 99) >= 18);
    end
  end

  initial begin : stimulus
    int sel, n, top;
    bit full_done;
    full_done = 1'b0;

    queue_search(32'h8000_0000);
    queue_request(REQ_UNUSED, '1, '1);
    queue_append(32'h8000_0000);
    queue_append(32'h0000_0000);
    queue_append(32'h7fff_ffff);
    queue_append(32'hffff_ffff);
    queue_append(32'h8000_0000);
    queue_search(32'h7fff_ffff);
    queue_search(32'h8000_0000);
    queue_search(32'h0000_0000);
    queue_search(32'hffff_ffff);
    queue_search(32'h0000_0005);
    queue_clear();
    queue_search(32'h0000_0000);
    queue_append(32'd1);
    queue_append(32'd2);
    queue_append(32'd3);
    queue_search(32'd1);
    queue_search(32'd3);
    queue_clear();
    queue_append(32'd7);
    queue_append(32'd7);
    queue_search(32'd7);

    while (counted_items < 1000) begin
      sel = $urandom_range(0, 99);
      if (!full_done && counted_items > 200) begin
        // fill the store, push past it, then search with the overflow flag set
        queue_clear();
        load_bitonic(bas_pkg::MaxElems, $urandom_range(0, bas_pkg::MaxElems - 1), 1'b0);
        repeat (3) queue_append($urandom);
        repeat (12) queue_search(pick_key());
        queue_search(gen_arr[bas_pkg::MaxElems-1]);
        full_done = 1'b1;
      end else if (sel < 70) begin
        if (sel < 62) queue_clear();
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        case ($urandom_range(0, 5))
          0: top = 0;
          1: top = n - 1;
          default: top = $urandom_range(0, n - 1);
        endcase
        load_bitonic(n, top, $urandom_range(0, 1));
        repeat ($urandom_range(3, 8)) queue_search(pick_key());
      end else if (sel < 85) begin
        queue_clear();
        repeat ($urandom_range(1, 10)) queue_append($urandom_range(0, 3));
        repeat ($urandom_range(2, 5)) queue_search(pick_key());
      end else begin
        repeat ($urandom_range(1, 6))
          queue_request(2'($urandom_range(0, 3)), $urandom, $urandom);
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (request_queue.size() != 0 || s_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
